// File: rtl/gapb_pkg.sv
// ----------------------------------------------------------------------------
// gapb_pkg: shared types and helpers for the glyph alpha pixel blender
// Word formats, blend mode codes, register indexes, pipeline stage numbering
// and the small arithmetic helpers that the datapath modules share.
// ----------------------------------------------------------------------------
package gapb_pkg;

   // Word formats of the two streaming channels.
   typedef struct packed {
      logic [7:0]  coverage;
      logic [31:0] dest_pixel;
   } gapb_req_type;

   typedef struct packed {
      logic [31:0] new_pixel;
      logic        pixel_written;
   } gapb_rsp_type;

   // Blend modes.
   localparam logic [1:0] MODE_TRANSPARENT = 2'd0;
   localparam logic [1:0] MODE_OPAQUE      = 2'd1;
   localparam logic [1:0] MODE_ALPHA       = 2'd2;
   localparam logic [1:0] MODE_SHADOW      = 2'd3;

   // Register indexes, taken from paddr[3:2].
   localparam int          CSR_ADDR_W     = 4;
   localparam logic [1:0] REG_BLEND_MODE = 2'd0;
   localparam logic [1:0] REG_FORE_COLOR = 2'd1;
   localparam logic [1:0] REG_BACK_COLOR = 2'd2;

   // Pixel masks.
   localparam logic [31:0] MASK_A    = 32'hff00_0000;
   localparam logic [31:0] MASK_HALF = 32'h007f_7f7f;
   localparam logic [7:0]  FULL      = 8'd255;

   // The rescale divider produces an 8-bit quotient, two bits per stage.
   localparam int QUO_W              = 8;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES         = QUO_W / DIV_BITS_PER_STAGE;

   // Pipeline stage numbering.
   localparam int STAGE_IN   = 0;
   localparam int STAGE_PROD = 1;
   localparam int STAGE_NA   = 2;
   localparam int STAGE_DIV0 = 3;
   localparam int STAGE_MIX  = STAGE_DIV0 + DIV_STAGES;
   localparam int STAGE_OUT  = STAGE_MIX + 1;
   localparam int NUM_STAGES = STAGE_OUT + 1;

   // Partial state of the restoring divider as it moves down the stages.
   typedef struct packed {
      logic [7:0] rem;
      logic [7:0] quo;
      logic [7:0] num_lo;
      logic [7:0] divisor;
   } gapb_div_type;

   // floor(x / 255), exact for every x up to 255 * 255.
   function automatic logic [7:0] div_by_255(input logic [15:0] x);
      logic [16:0] s;
      s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
      return s[15:8];
   endfunction

   // One restoring division step: returns the quotient bit above the new remainder.
   function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                           input logic [7:0] divisor);
      logic [8:0] t;
      logic       q;
      t = {rem, nbit};
      q = (t >= {1'b0, divisor});
      if (q) begin
         t = t - {1'b0, divisor};
      end
      return {q, t[7:0]};
   endfunction

   // d * (255 - a) + s * a for one 8-bit channel.
   function automatic logic [15:0] mix_chan(input logic [7:0] d, input logic [7:0] s,
                                            input logic [7:0] a);
      return 16'(d) * 16'(FULL - a) + 16'(s) * 16'(a);
   endfunction

endpackage

// File: rtl/gapb_div_stage.sv
// ----------------------------------------------------------------------------
// gapb_div_stage: one register stage of the coverage rescale divider
// Runs two restoring division steps on the carried partial state and
// registers the result when the stage is allowed to advance.
// ----------------------------------------------------------------------------
module gapb_div_stage (
   input  logic                  clock,
   input  logic                  enable,
   input  gapb_pkg::gapb_div_type step_src,
   output gapb_pkg::gapb_div_type step_dst
);
   import gapb_pkg::*;

   gapb_div_type div_in;
   gapb_div_type div_ff;
   logic [8:0]   step_res;

   always_comb begin
      div_in   = step_src;
      step_res = '0;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         step_res       = div_step(div_in.rem, div_in.num_lo[7], div_in.divisor);
         div_in.rem     = step_res[7:0];
         div_in.quo     = {div_in.quo[6:0], step_res[8]};
         div_in.num_lo  = {div_in.num_lo[6:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         div_ff <= div_in;
      end
   end

   assign step_dst = div_ff;

endmodule

// File: rtl/glyph_alpha_pixel_blend.sv
// ----------------------------------------------------------------------------
// glyph_alpha_pixel_blend: ARGB8888 glyph coverage blender
// Blends one glyph coverage byte into one destination pixel per word under
// the configured transparent, opaque, alpha or shadow mode.
// ----------------------------------------------------------------------------
// The block takes one word per clock and returns one result word per clock
// while the result side does not stall. Every word passes through nine
// register stages on its way to rsp_valid; the length is set by
// the transparent-mode path, which forms the composed alpha with an 8x8
// multiply and a divide by 255, then rescales the coverage through a
// restoring divider that resolves two quotient bits per stage over four
// stages, and finally mixes the three colour channels. Each stage has its
// own valid bit and advances whenever the stage after it is free, so empty
// slots close up while the result side stalls and new words keep being
// accepted until the pipeline is full. The configuration registers are
// written through the APB port and read directly by the stages, so they must
// only be changed while no word is in flight.
// ----------------------------------------------------------------------------
module glyph_alpha_pixel_blend (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input word channel.
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  gapb_pkg::gapb_req_type               req_data,
   // Result word channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output gapb_pkg::gapb_rsp_type               rsp_data,
   // Configuration port.
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gapb_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import gapb_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers. A write lands in the access phase; the low
   // two address bits are ignored and index three holds nothing.
   // ---------------------------------------------------------------------
   logic [1:0]  mode_ff, mode_in;
   logic [31:0] fore_ff, fore_in;
   logic [31:0] back_ff, back_in;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      mode_in = mode_ff;
      fore_in = fore_ff;
      back_in = back_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            REG_BLEND_MODE: mode_in = pwdata[1:0];
            REG_FORE_COLOR: fore_in = pwdata;
            REG_BACK_COLOR: back_in = pwdata;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TRANSPARENT;
         fore_ff <= '0;
         back_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         fore_ff <= fore_in;
         back_ff <= back_in;
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_BLEND_MODE: prdata = 32'(mode_ff);
         REG_FORE_COLOR: prdata = fore_ff;
         REG_BACK_COLOR: prdata = back_ff;
         default:        prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control. A stage may load when it is empty or when the stage
   // after it loads too; the output stage frees up when the result is taken.
   // ---------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] stage_en;

   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = valid_ff;
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (stage_en[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_en[STAGE_IN];

   // Coverage and destination pixel travel alongside up to the mix stage.
   gapb_req_type ctx_ff [STAGE_MIX];

   always_ff @(posedge clock) begin
      if (stage_en[STAGE_IN]) begin
         ctx_ff[STAGE_IN] <= req_data;
      end
   end

   for (genvar k = 1; k < STAGE_MIX; k++) begin : g_ctx
      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            ctx_ff[k] <= ctx_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Transparent alpha: (255 - c) * (255 - da), then na = 255 - that / 255.
   // ---------------------------------------------------------------------
   logic [15:0]  prod_ff, prod_in;
   gapb_div_type div_init_ff, div_init_in;
   logic [15:0]  cov_scaled;
   logic [7:0]   na_value;

   assign prod_in = 16'(FULL - ctx_ff[STAGE_IN].coverage)
                  * 16'(FULL - ctx_ff[STAGE_IN].dest_pixel[31:24]);

   always_ff @(posedge clock) begin
      if (stage_en[STAGE_PROD]) begin
         prod_ff <= prod_in;
      end
   end

   // The divider computes floor(c * 255 / na). Since na is never below c,
   // the top byte of the dividend is already below na and the quotient fits
   // in eight bits, so the clamp at 255 never acts.
   always_comb begin
      cov_scaled          = {ctx_ff[STAGE_PROD].coverage, 8'd0}
                          - 16'(ctx_ff[STAGE_PROD].coverage);
      na_value            = FULL - div_by_255(prod_ff);
      div_init_in.rem     = cov_scaled[15:8];
      div_init_in.quo     = '0;
      div_init_in.num_lo  = cov_scaled[7:0];
      div_init_in.divisor = na_value;
   end

   always_ff @(posedge clock) begin
      if (stage_en[STAGE_NA]) begin
         div_init_ff <= div_init_in;
      end
   end

   // ---------------------------------------------------------------------
   // Coverage rescale divider.
   // ---------------------------------------------------------------------
   gapb_div_type div_chain [DIV_STAGES + 1];

   assign div_chain[0] = div_init_ff;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      gapb_div_stage u_div_stage (
         .clock    (clock),
         .enable   (stage_en[STAGE_DIV0 + g]),
         .step_src (div_chain[g]),
         .step_dst (div_chain[g+1])
      );
   end

   // ---------------------------------------------------------------------
   // Mix stage: choose operands by mode and form the per-channel sums
   // d * (255 - a) + s * a. Full and empty coverage take a direct result.
   // ---------------------------------------------------------------------
   gapb_req_type ctx_mix;
   logic [31:0]  half_pixel;
   logic [23:0]  mix_d, mix_s;
   logic [7:0]   mix_a;
   logic [7:0]   alpha_in, alpha_ff;
   logic [31:0]  direct_in, direct_ff;
   logic         use_mix_in, use_mix_ff;
   logic         written_in, written_ff;
   logic [15:0]  sum_in [3];
   logic [15:0]  sum_ff [3];

   assign ctx_mix    = ctx_ff[STAGE_MIX-1];
   assign half_pixel = (ctx_mix.dest_pixel >> 1) & MASK_HALF;

   always_comb begin
      mix_d      = ctx_mix.dest_pixel[23:0];
      mix_s      = fore_ff[23:0];
      mix_a      = ctx_mix.coverage;
      alpha_in   = ctx_mix.dest_pixel[31:24];
      direct_in  = ctx_mix.dest_pixel;
      use_mix_in = 1'b0;
      written_in = 1'b1;
      unique case (mode_ff)
         MODE_TRANSPARENT: begin
            if (ctx_mix.coverage == '0) begin
               written_in = 1'b0;
            end else if (ctx_mix.coverage == FULL) begin
               direct_in = fore_ff | MASK_A;
            end else begin
               use_mix_in = 1'b1;
               alpha_in   = div_chain[DIV_STAGES].divisor;
               mix_a      = div_chain[DIV_STAGES].quo;
            end
         end
         MODE_OPAQUE: begin
            if (ctx_mix.coverage == '0) begin
               direct_in = back_ff;
            end else if (ctx_mix.coverage == FULL) begin
               direct_in = {back_ff[31:24], fore_ff[23:0]};
            end else begin
               use_mix_in = 1'b1;
               alpha_in   = back_ff[31:24];
               mix_d      = back_ff[23:0];
            end
         end
         MODE_ALPHA: begin
            direct_in = {ctx_mix.coverage, fore_ff[23:0]};
         end
         MODE_SHADOW: begin
            if (ctx_mix.coverage == '0) begin
               written_in = 1'b0;
            end else if (ctx_mix.coverage == FULL) begin
               direct_in = half_pixel;
            end else begin
               use_mix_in = 1'b1;
               mix_s      = half_pixel[23:0];
            end
         end
         default: ;
      endcase
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = mix_chan(mix_d[8*ch +: 8], mix_s[8*ch +: 8], mix_a);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[STAGE_MIX]) begin
         alpha_ff   <= alpha_in;
         direct_ff  <= direct_in;
         use_mix_ff <= use_mix_in;
         written_ff <= written_in;
         sum_ff     <= sum_in;
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: divide each channel sum by 255 and assemble the pixel.
   // ---------------------------------------------------------------------
   gapb_rsp_type out_ff, out_in;

   always_comb begin
      out_in.pixel_written = written_ff;
      if (use_mix_ff) begin
         out_in.new_pixel = {alpha_ff, div_by_255(sum_ff[2]), div_by_255(sum_ff[1]),
                             div_by_255(sum_ff[0])};
      end else begin
         out_in.new_pixel = direct_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[STAGE_OUT]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = valid_ff[STAGE_OUT];
   assign rsp_data  = out_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   logic partial_na;
   logic partial_quo;

   assign partial_na  = valid_ff[STAGE_NA] && (mode_ff == MODE_TRANSPARENT)
                     && (ctx_ff[STAGE_NA].coverage != '0)
                     && (ctx_ff[STAGE_NA].coverage != FULL);
   assign partial_quo = valid_ff[STAGE_MIX-1] && (mode_ff == MODE_TRANSPARENT)
                     && (ctx_mix.coverage != '0) && (ctx_mix.coverage != FULL);

   // The composed alpha never drops below the coverage, so the divisor is nonzero.
   assert property (@(posedge clock) disable iff (reset)
      partial_na |-> (div_init_ff.divisor >= ctx_ff[STAGE_NA].coverage))
      else $error("composed alpha below coverage");

   // After the last divider stage the remainder is below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      partial_quo |-> (div_chain[DIV_STAGES].rem < div_chain[DIV_STAGES].divisor))
      else $error("divider remainder out of range");

   // A word in the mix stage moves on to the output when the output may load.
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[STAGE_MIX] && stage_en[STAGE_OUT]) |=> valid_ff[STAGE_OUT])
      else $error("word lost between mix and output stages");

   // Only the transparent and shadow modes leave a pixel untouched.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.pixel_written)
         |-> ((mode_ff == MODE_TRANSPARENT) || (mode_ff == MODE_SHADOW)))
      else $error("pixel left untouched in a writing mode");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the glyph alpha pixel blender
// Streams coverage/pixel words through the block under all four blend modes,
// predicts every result word in the bench and compares it field by field,
// while both sides of the stream stall at random and the registers are
// rewritten between phases.
// ----------------------------------------------------------------------------
module tb;
   import gapb_pkg::*;

   // Cycles without any handshake before the run is declared hung. A correct
   // run never comes close: the pipeline is nine stages deep and idles are
   // short random gaps.
   localparam int HANG_LIMIT   = 5000;
   // Extra cycles after the last result so a stray word would still show up.
   localparam int TAIL_CYCLES  = 12;
   localparam int MAX_REPORTS  = 10;
   localparam int RAND_PHASES  = 8;
   localparam int PHASE_WORDS  = 210;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   gapb_req_type          req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   gapb_rsp_type          rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   // The bench's own copy of the configuration registers.
   logic [1:0]            cur_mode;
   logic [31:0]           cur_fore;
   logic [31:0]           cur_back;

   // Results predicted for accepted words, oldest first.
   gapb_rsp_type          pending_pixels[$];

   // When clear, the sender never inserts gaps and the receiver never stalls.
   bit                    idle_on;

   int                    error_count;
   int                    words_sent;
   int                    results_checked;
   int                    reg_accesses;
   int                    mode_words[4];

   glyph_alpha_pixel_blend i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // One colour channel mixed as floor((d*(255-a) + s*a) / 255).
   function automatic logic [7:0] mix_byte(input logic [7:0] d, input logic [7:0] s,
                                           input int unsigned a);
      int unsigned v;
      v = int'(d) * (255 - a) + int'(s) * a;
      return 8'(v / 255);
   endfunction

   function automatic logic [23:0] mix_rgb(input logic [31:0] d, input logic [31:0] s,
                                           input int unsigned a);
      return {mix_byte(d[23:16], s[23:16], a), mix_byte(d[15:8], s[15:8], a),
              mix_byte(d[7:0], s[7:0], a)};
   endfunction

   // The result word that the current register settings give for one input word.
   function automatic gapb_rsp_type blended_pixel(input logic [7:0] cov,
                                                  input logic [31:0] dst);
      gapb_rsp_type r;
      int unsigned  c;
      int unsigned  da;
      int unsigned  na;
      int unsigned  a;
      logic [31:0]  half;
      c               = cov;
      r.new_pixel     = dst;
      r.pixel_written = 1'b1;
      case (cur_mode)
         MODE_TRANSPARENT: begin
            if (c == 0) begin
               r.pixel_written = 1'b0;
            end else if (c == 255) begin
               r.new_pixel = cur_fore | MASK_A;
            end else begin
               // Compose the alpha first, then rescale the coverage against it.
               // The composed alpha is at least the coverage, so it is never zero.
               da = dst[31:24];
               na = 255 - ((255 - c) * (255 - da)) / 255;
               a  = (c * 255) / na;
               if (a > 255) begin
                  a = 255;
               end
               r.new_pixel = {8'(na), mix_rgb(dst, cur_fore, a)};
            end
         end
         MODE_OPAQUE: begin
            if (c == 0) begin
               r.new_pixel = cur_back;
            end else if (c == 255) begin
               r.new_pixel = {cur_back[31:24], cur_fore[23:0]};
            end else begin
               r.new_pixel = {cur_back[31:24], mix_rgb(cur_back, cur_fore, c)};
            end
         end
         MODE_ALPHA: begin
            r.new_pixel = {cov, cur_fore[23:0]};
         end
         default: begin
            half = (dst >> 1) & MASK_HALF;
            if (c == 0) begin
               r.pixel_written = 1'b0;
            end else if (c == 255) begin
               r.new_pixel = half;
            end else begin
               r.new_pixel = {dst[31:24], mix_rgb(dst, half, c)};
            end
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("tb: mismatch in %s: expected %08h, got %08h", what, exp_v, act_v);
      end
   endtask

   // Every result word accepted by the bench is compared with the oldest
   // prediction. The handshake is sampled at the edge, before any update of
   // that edge lands, so the values seen are the ones the block presented.
   always @(posedge clock) begin
      gapb_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("result word with nothing pending", 32'h0, rsp_data.new_pixel);
         end else begin
            want = pending_pixels.pop_front();
            results_checked++;
            if (rsp_data.new_pixel !== want.new_pixel) begin
               report_mismatch("new_pixel", want.new_pixel, rsp_data.new_pixel);
            end
            if (rsp_data.pixel_written !== want.pixel_written) begin
               report_mismatch("pixel_written", 32'(want.pixel_written),
                               32'(rsp_data.pixel_written));
            end
         end
      end
   end

   // The receiver stalls at random, about nine times in a hundred, while idling is on.
   always @(posedge clock) begin
      if (idle_on) begin
         rsp_ready <= ($urandom_range(99) >= 9);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Hang detector: any handshake on any port restarts the count. Running out
   // ends the run as a failure.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < HANG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
             || (psel && penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("tb: no handshake for %0d cycles", HANG_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Register port
   // ------------------------------------------------------------------------

   // One APB transfer: a setup phase, then the access phase until pready.
   // Read data is taken at the completing edge.
   task automatic apb_transfer(input bit is_write, input logic [1:0] idx,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      reg_accesses++;
   endtask

   // Reads a register back and compares the bits it holds with the bench copy.
   task automatic reg_check(input logic [1:0] idx);
      logic [31:0] rdata;
      apb_transfer(1'b0, idx, 32'h0, rdata);
      case (idx)
         REG_BLEND_MODE: begin
            if (rdata[1:0] !== cur_mode) begin
               report_mismatch("blend_mode readback", 32'(cur_mode), 32'(rdata[1:0]));
            end
         end
         REG_FORE_COLOR: begin
            if (rdata !== cur_fore) begin
               report_mismatch("fore_color readback", cur_fore, rdata);
            end
         end
         REG_BACK_COLOR: begin
            if (rdata !== cur_back) begin
               report_mismatch("back_color readback", cur_back, rdata);
            end
         end
         default: begin
         end
      endcase
   endtask

   // Writes a register, mirrors the write in the bench copy and reads it back.
   // Bits above a register's width are dropped; an unused index changes nothing.
   task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
      logic [31:0] unused;
      apb_transfer(1'b1, idx, value, unused);
      case (idx)
         REG_BLEND_MODE: cur_mode = value[1:0];
         REG_FORE_COLOR: cur_fore = value;
         REG_BACK_COLOR: cur_back = value;
         default: begin
         end
      endcase
      reg_check(idx);
   endtask

   task automatic set_colors_and_mode(input logic [1:0] mode, input logic [31:0] fore,
                                      input logic [31:0] back);
      // Upper bits of the mode write carry noise that the register must drop.
      reg_write(REG_BLEND_MODE, {30'($urandom() >> 2), mode});
      reg_write(REG_FORE_COLOR, fore);
      reg_write(REG_BACK_COLOR, back);
   endtask

   // ------------------------------------------------------------------------
   // Word stream
   // ------------------------------------------------------------------------

   // Sends one word. Valid stays high from one word to the next unless the
   // sender decides to idle, so it is never lowered and raised in one step.
   task automatic send_word(input logic [7:0] cov, input logic [31:0] dst);
      gapb_req_type w;
      w.coverage   = cov;
      w.dest_pixel = dst;
      while (idle_on && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_pixels.push_back(blended_pixel(cov, dst));
      words_sent++;
      mode_words[cur_mode]++;
   endtask

   // The sender stops and waits until every pending result has come back.
   // Each word gives exactly one result, so the pipeline is then empty and
   // the registers may be changed safely.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   // Coverage leans on the special values: empty, full and their neighbours.
   function automatic logic [7:0] random_coverage();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) begin
         return 8'd0;
      end else if (r < 16) begin
         return 8'd255;
      end else if (r < 20) begin
         return 8'd1;
      end else if (r < 24) begin
         return 8'd254;
      end
      return 8'($urandom_range(255));
   endfunction

   // Destination alpha of zero and of 255 are the corners of the alpha compose.
   function automatic logic [31:0] random_dest();
      int unsigned r;
      logic [31:0] v;
      r = $urandom_range(99);
      v = $urandom();
      if (r < 10) begin
         v[31:24] = 8'h00;
      end else if (r < 20) begin
         v[31:24] = 8'hff;
      end else if (r < 25) begin
         v = 32'h0000_0000;
      end else if (r < 30) begin
         v = 32'hffff_ffff;
      end
      return v;
   endfunction

   function automatic logic [31:0] random_color();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 15) begin
         return 32'h0000_0000;
      end else if (r < 30) begin
         return 32'hffff_ffff;
      end
      return $urandom();
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Registers read back as zero after reset, and the block blends with the
   // reset settings: transparent mode and a black foreground.
   task automatic test_reset_defaults();
      reg_check(REG_BLEND_MODE);
      reg_check(REG_FORE_COLOR);
      reg_check(REG_BACK_COLOR);
      send_word(8'd255, 32'h1234_5678);
      send_word(8'd0, 32'hffff_ffff);
      send_word(8'd77, 32'h4080_c0ff);
      wait_drained();
   endtask

   // Each mode with empty, full and partial coverage, at the pixel extremes.
   task automatic test_directed_modes();
      // Transparent: untouched pixel, full foreground, a rescale up to 255 with
      // a clear destination, and an opaque destination.
      set_colors_and_mode(MODE_TRANSPARENT, 32'hffff_ffff, 32'h0000_0000);
      send_word(8'd0, 32'h8765_4321);
      send_word(8'd255, 32'h0000_0000);
      send_word(8'd1, 32'h0000_0000);
      send_word(8'd254, 32'hffff_ffff);
      send_word(8'd128, 32'h8040_2010);
      wait_drained();
      set_colors_and_mode(MODE_OPAQUE, 32'hffff_ffff, 32'h0000_0000);
      send_word(8'd0, 32'hffff_ffff);
      send_word(8'd255, 32'h0000_0000);
      send_word(8'd100, 32'h5a5a_5a5a);
      wait_drained();
      set_colors_and_mode(MODE_OPAQUE, 32'h0000_0000, 32'hffff_ffff);
      send_word(8'd1, 32'h0000_0000);
      send_word(8'd254, 32'hffff_ffff);
      wait_drained();
      // Alpha mode: the foreground's own alpha byte must not leak out.
      set_colors_and_mode(MODE_ALPHA, 32'hffff_ffff, 32'h0000_0000);
      send_word(8'd0, 32'hffff_ffff);
      send_word(8'd255, 32'h0000_0000);
      send_word(8'h5a, 32'ha5a5_a5a5);
      wait_drained();
      // Shadow: untouched pixel, full darkening with alpha cleared, partial.
      set_colors_and_mode(MODE_SHADOW, 32'h0000_0000, 32'hffff_ffff);
      send_word(8'd0, 32'hffff_ffff);
      send_word(8'd255, 32'hffff_ffff);
      send_word(8'd1, 32'hffff_ffff);
      send_word(8'd200, 32'h8080_8080);
      wait_drained();
   endtask

   // A write to the unused register index must leave every register alone.
   task automatic test_unused_index();
      set_colors_and_mode(MODE_OPAQUE, 32'h11aa_22bb, 32'hcc33_dd44);
      reg_write(2'd3, 32'hffff_ffff);
      reg_write(2'd3, $urandom());
      reg_check(REG_BLEND_MODE);
      reg_check(REG_FORE_COLOR);
      reg_check(REG_BACK_COLOR);
      send_word(8'd0, 32'h0);
      send_word(8'd255, 32'h0);
      send_word(8'd64, 32'h0);
      wait_drained();
   endtask

   // Random words over several register settings. One phase runs with no
   // idling on either side; halfway through each phase the sender also
   // pauses until the pipeline has drained.
   task automatic test_random_phases();
      int phase;
      int n;
      for (phase = 0; phase < RAND_PHASES; phase++) begin
         set_colors_and_mode(2'(phase), random_color(), random_color());
         idle_on = (phase != 5);
         for (n = 0; n < PHASE_WORDS; n++) begin
            if (n == PHASE_WORDS / 2) begin
               wait_drained();
            end
            send_word(random_coverage(), random_dest());
         end
         wait_drained();
      end
      idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      cur_mode        = MODE_TRANSPARENT;
      cur_fore        = 32'h0;
      cur_back        = 32'h0;
      idle_on         = 1'b1;
      error_count     = 0;
      words_sent      = 0;
      results_checked = 0;
      reg_accesses    = 0;
      mode_words      = '{default: 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_directed_modes();
      test_unused_index();
      test_random_phases();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      error_count += pending_pixels.size();

      $display("tb: %0d words sent (transparent %0d, opaque %0d, alpha %0d, shadow %0d)",
               words_sent, mode_words[MODE_TRANSPARENT], mode_words[MODE_OPAQUE],
               mode_words[MODE_ALPHA], mode_words[MODE_SHADOW]);
      $display("tb: %0d results compared, %0d register accesses, %0d mismatches",
               results_checked, reg_accesses, error_count);
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/gapb_pkg.sv
rtl/gapb_div_stage.sv
rtl/glyph_alpha_pixel_blend.sv
tb/sv/tb.sv
